// File: hdl/ofp_pkg.sv
// Shared types and constants for the oximeter frame parser with pleth trigger.
// No dependencies; imported by oximeter_frame_parser_pulse_trigger_top.
`default_nettype none
package ofp_pkg;

  // item fields
  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       sample_valid;
    logic [7:0] pleth_sample;
    logic [7:0] trigger_mark;
    logic       trigger_active;
    logic [6:0] heart_rate_high;
    logic [7:0] heart_rate_low;
    logic [7:0] oxygen_saturation;
  } out_item_t;

  // input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOPE_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RISE_RUN_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF_TICKS   = 2'd2;

  localparam logic [6:0] RST_SLOPE_THRESHOLD = 7'd3;
  localparam logic [3:0] RST_RISE_RUN_LENGTH = 4'd2;
  localparam logic [9:0] RST_HOLDOFF_TICKS   = 10'd200;

  // parser phases
  localparam logic [2:0] PH_SYNC    = 3'd0;
  localparam logic [2:0] PH_STATUS  = 3'd1;
  localparam logic [2:0] PH_PLETH   = 3'd2;
  localparam logic [2:0] PH_HRHIGH  = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  // frame layout
  localparam logic [7:0] SYNC_BYTE    = 8'h01;
  localparam logic [7:0] BYTE_LIMIT   = 8'd127;
  localparam logic [6:0] PAYLOAD_LEN  = 7'd120;
  localparam logic [6:0] PLETH_STRIDE = 7'd5;
  localparam logic [6:0] FIRST_PLETH  = 7'd3;
  localparam logic [6:0] HR_LOW_POS   = 7'd4;
  localparam logic [6:0] SPO2_POS     = 7'd9;

  localparam logic [3:0] RISE_MAX     = 4'd15;
  localparam logic [9:0] HOLDOFF_MAX  = 10'd1023;

endpackage
`default_nettype wire

// File: hdl/oximeter_frame_parser_pulse_trigger_top.sv
// Oximeter five-byte frame parser with pleth slope trigger and tick holdoff.
// Depends on ofp_pkg.
//
// Usage:
//   in channel (in_valid/in_ready/in_data): one item per serial byte
//   (action = byte) or per timer tick (action = tick).
//   out channel (out_valid/out_ready/out_data): exactly one result item per
//   input item, in order: pleth sample if one was taken, trigger mark, trigger
//   flag and the latest heart-rate and SpO2 bytes.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//   only while no item is in flight. Index 0 slope threshold, 1 rise run
//   length, 2 holdoff ticks; other indexes are ignored.
// Timing: an item is registered at the input, then parsed and run through the
//   trigger combinationally into the output register: one item per cycle
//   sustained while out_ready is high; state updates with the result.
// Reset: parser waits for sync, all stored values zero, trigger armed,
//   registers at 3 / 2 / 200.
// Stall: while out_ready is low the result holds; one more item is taken into
//   the input register, then in_ready drops until the output drains.
`default_nettype none
module oximeter_frame_parser_pulse_trigger_top (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  ofp_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output ofp_pkg::out_item_t                out_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [ofp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire  [ofp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ofp_pkg::*;

  // configuration
  logic [6:0] slope_threshold;
  logic [3:0] rise_run_length;
  logic [9:0] holdoff_ticks;

  // input register
  logic     s1_valid;
  in_item_t s1_item;
  logic     advance;

  // state
  logic [2:0] parse_phase,         parse_phase_next;
  logic [7:0] running_sum,         running_sum_next;
  logic [6:0] byte_count,          byte_count_next;
  logic [6:0] next_pleth_position, next_pleth_position_next;
  logic [7:0] held_pleth,          held_pleth_next;
  logic [6:0] hr_high_reg,         hr_high_reg_next;
  logic [7:0] hr_low_reg,          hr_low_reg_next;
  logic [7:0] spo2_reg,            spo2_reg_next;
  logic [7:0] previous_pleth,      previous_pleth_next;
  logic [3:0] rise_count,          rise_count_next;
  logic       rising_phase,        rising_phase_next;
  logic       trigger_flag,        trigger_flag_next;
  logic [9:0] holdoff_count,       holdoff_count_next;

  // per-item logic
  logic       have_sample;
  logic [7:0] sample;
  logic [7:0] mark;
  logic [6:0] count_inc;
  logic [7:0] diff;
  logic [8:0] steep_sum;
  logic       steep;
  logic       flat;
  logic [3:0] rise_inc;
  logic [9:0] hold_inc;
  out_item_t  result;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_threshold <= RST_SLOPE_THRESHOLD;
      rise_run_length <= RST_RISE_RUN_LENGTH;
      holdoff_ticks   <= RST_HOLDOFF_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SLOPE_THRESHOLD: slope_threshold <= cfg_data[6:0];
        REG_RISE_RUN_LENGTH: rise_run_length <= cfg_data[3:0];
        REG_HOLDOFF_TICKS:   holdoff_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  always_comb begin
    parse_phase_next         = parse_phase;
    running_sum_next         = running_sum;
    byte_count_next          = byte_count;
    next_pleth_position_next = next_pleth_position;
    held_pleth_next          = held_pleth;
    hr_high_reg_next         = hr_high_reg;
    hr_low_reg_next          = hr_low_reg;
    spo2_reg_next            = spo2_reg;
    previous_pleth_next      = previous_pleth;
    rise_count_next          = rise_count;
    rising_phase_next        = rising_phase;
    trigger_flag_next        = trigger_flag;
    holdoff_count_next       = holdoff_count;
    have_sample              = 1'b0;
    sample                   = 8'd0;
    mark                     = 8'd0;
    count_inc                = byte_count + 7'd1;
    hold_inc                 = (holdoff_count < HOLDOFF_MAX) ? holdoff_count + 10'd1
                                                             : holdoff_count;

    if (s1_item.action == ACT_TICK) begin
      if (trigger_flag) begin
        holdoff_count_next = hold_inc;
        if (hold_inc >= holdoff_ticks) begin
          trigger_flag_next  = 1'b0;
          holdoff_count_next = 10'd0;
        end
      end
    end else begin
      case (parse_phase)
        PH_STATUS: begin
          if (s1_item.data_byte > BYTE_LIMIT && s1_item.data_byte[0]) begin
            parse_phase_next = PH_PLETH;
            running_sum_next = running_sum + s1_item.data_byte;
          end else begin
            parse_phase_next = PH_SYNC;
          end
        end
        PH_PLETH: begin
          held_pleth_next          = s1_item.data_byte;
          running_sum_next         = running_sum + s1_item.data_byte;
          next_pleth_position_next = FIRST_PLETH;
          parse_phase_next         = PH_HRHIGH;
        end
        PH_HRHIGH: begin
          if (s1_item.data_byte < BYTE_LIMIT) begin
            hr_high_reg_next = s1_item.data_byte[6:0];
            running_sum_next = running_sum + s1_item.data_byte;
            parse_phase_next = PH_CHECK;
          end else begin
            parse_phase_next = PH_SYNC;
          end
        end
        PH_CHECK: begin
          if (s1_item.data_byte == running_sum) begin
            have_sample      = 1'b1;
            sample           = held_pleth;
            byte_count_next  = 7'd0;
            parse_phase_next = PH_PAYLOAD;
          end else begin
            parse_phase_next = PH_SYNC;
          end
        end
        PH_PAYLOAD: begin
          byte_count_next = count_inc;
          if (count_inc == next_pleth_position) begin
            have_sample              = 1'b1;
            sample                   = s1_item.data_byte;
            next_pleth_position_next = next_pleth_position + PLETH_STRIDE;
          end else if (count_inc == HR_LOW_POS) begin
            hr_low_reg_next = s1_item.data_byte;
          end else if (count_inc == SPO2_POS) begin
            spo2_reg_next = s1_item.data_byte;
          end else if (count_inc == PAYLOAD_LEN) begin
            parse_phase_next = PH_SYNC;
          end
        end
        default: begin
          parse_phase_next = PH_SYNC;
          if (s1_item.data_byte == SYNC_BYTE) begin
            parse_phase_next = PH_STATUS;
            running_sum_next = SYNC_BYTE;
          end
        end
      endcase
    end

    // slope trigger: diff = previous - sample, two's complement
    diff      = previous_pleth - sample;
    steep_sum = {diff[7], diff} + {2'b00, slope_threshold};
    steep     = steep_sum[8] || (steep_sum == 9'd0);
    flat      = !diff[7] && (diff[6:0] <= slope_threshold);
    rise_inc  = steep ? ((rise_count < RISE_MAX) ? rise_count + 4'd1 : rise_count) : 4'd0;

    if (have_sample && !trigger_flag) begin
      if (rising_phase) begin
        rise_count_next = rise_inc;
        if (rise_inc >= rise_run_length) begin
          trigger_flag_next  = 1'b1;
          rising_phase_next  = 1'b0;
          rise_count_next    = 4'd0;
          holdoff_count_next = 10'd0;
          mark               = sample;
        end
      end else if (flat) begin
        rising_phase_next = 1'b1;
        rise_count_next   = 4'd0;
      end
      previous_pleth_next = sample;
    end

    result.sample_valid      = have_sample;
    result.pleth_sample      = sample;
    result.trigger_mark      = mark;
    result.trigger_active    = trigger_flag_next;
    result.heart_rate_high   = hr_high_reg_next;
    result.heart_rate_low    = hr_low_reg_next;
    result.oxygen_saturation = spo2_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase         <= PH_SYNC;
      running_sum         <= 8'd0;
      byte_count          <= 7'd0;
      next_pleth_position <= 7'd0;
      held_pleth          <= 8'd0;
      hr_high_reg         <= 7'd0;
      hr_low_reg          <= 8'd0;
      spo2_reg            <= 8'd0;
      previous_pleth      <= 8'd0;
      rise_count          <= 4'd0;
      rising_phase        <= 1'b1;
      trigger_flag        <= 1'b0;
      holdoff_count       <= 10'd0;
    end else if (advance) begin
      parse_phase         <= parse_phase_next;
      running_sum         <= running_sum_next;
      byte_count          <= byte_count_next;
      next_pleth_position <= next_pleth_position_next;
      held_pleth          <= held_pleth_next;
      hr_high_reg         <= hr_high_reg_next;
      hr_low_reg          <= hr_low_reg_next;
      spo2_reg            <= spo2_reg_next;
      previous_pleth      <= previous_pleth_next;
      rise_count          <= rise_count_next;
      rising_phase        <= rising_phase_next;
      trigger_flag        <= trigger_flag_next;
      holdoff_count       <= holdoff_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // checks
  a_mark_is_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.trigger_mark != 8'd0 |->
      out_data.sample_valid && out_data.trigger_active &&
      out_data.trigger_mark == out_data.pleth_sample)
    else $error("trigger mark without matching sample");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    parse_phase <= PH_PAYLOAD)
    else $error("parser phase out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= PAYLOAD_LEN)
    else $error("payload byte count past frame end");

  a_holdoff_only_triggered: assert property (@(posedge clk) disable iff (rst)
    holdoff_count != 10'd0 |-> trigger_flag)
    else $error("holdoff running with trigger clear");

  a_armed_when_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(trigger_flag) |-> $past(s1_item.action) == ACT_TICK)
    else $error("trigger cleared by a byte");

endmodule
`default_nettype wire
